// File: design/adam_pkg.sv
// Shared widths, register codes, reset values and types for the Adam update block.
`timescale 1ns / 1ps

package adam_pkg;

    // Default number of parameter elements held in the state memory.
    localparam int ELEMENTS_DEFAULT = 1024;

    // Field widths.
    localparam int IDX_W      = 10;
    localparam int DATA_W     = 32;
    localparam int VEL_W      = 48;
    localparam int BETA_W     = 16;
    localparam int EPS_W      = 16;
    localparam int LR_W       = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 32;

    // Datapath widths for the root, the quotient and the step.
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int NUM_W  = 64;
    localparam int DEN_W  = 40;
    localparam int STEP_W = 57;

    // Saturation limits.
    localparam logic [DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;
    localparam logic [VEL_W-1:0]  VEL_CAP  = 48'h4000_0000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BETA_FIRST    = 3'd0,
        REG_BETA_SECOND   = 3'd1,
        REG_EPSILON       = 3'd2,
        REG_LEARN_RATE    = 3'd3,
        REG_MAXIMIZE      = 3'd4,
        REG_MOMENTUM_SQ   = 3'd5
    } cfg_reg_t;

    // Configuration register file.
    typedef struct packed {
        logic [BETA_W-1:0] beta_first;
        logic [BETA_W-1:0] beta_second;
        logic [EPS_W-1:0]  epsilon;
        logic [LR_W-1:0]   learn_rate;
        logic              maximize_mode;
        logic              momentum_squared_mode;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        beta_first:            16'd58982,
        beta_second:           16'd65470,
        epsilon:               16'd43,
        learn_rate:            24'd16777,
        maximize_mode:         1'b0,
        momentum_squared_mode: 1'b0
    };

endpackage

// File: design/adam_optimizer_update.sv
// Top level of the Adam parameter update: moment memory, update pipeline and output buffer.
`timescale 1ns / 1ps
//
// Channel   Direction  Transfer carries
// s_        in         elem_index, gradient, param_value (one parameter element)
// m_        out        new_param (one result per accepted element)
// cfg_      in         register index and write data, no handshake
//
// One element is accepted per cycle unless the interlock, the clearing pass or a full skid
// register holds s_tready low; results pass the 32-stage root and the 64-stage divider.
// Moments live in one memory, read at acceptance and written five stages later; an
// element whose index is still in those five stages holds s_tready low until written.
// After reset a clearing pass writes ELEMENTS zero entries, one per cycle, before the
// first transfer. A skid register lets the pipeline run on while one result waits.

module adam_optimizer_update #(
    parameter int ELEMENTS = adam_pkg::ELEMENTS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: elem_index[9:0], gradient[41:10], param_value[73:42], zero fill[79:74]
    input  logic [adam_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: new_param[31:0]
    output logic [adam_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [adam_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [adam_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int AW  = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int IW  = adam_pkg::IDX_W;
    localparam int XW  = adam_pkg::DATA_W;
    localparam int VW  = adam_pkg::VEL_W;
    localparam int MW  = XW + VW;
    localparam int SPW = 2 * XW;
    localparam int DPW = XW + 3;
    localparam logic [AW-1:0] LAST_ADDR = AW'(ELEMENTS - 1);

    adam_pkg::cfg_t cfg_reg;

    logic              en;
    logic              accept;
    logic              conflict;
    logic [IW-1:0]     in_idx;
    logic [XW-1:0]     in_grad;
    logic [XW-1:0]     in_param;
    logic [IW-1:0]     idx_red;
    logic [IW+AW-1:0]  idx_ext;
    logic [AW-1:0]     in_addr;
    logic [XW-1:0]     grad_eff;

    logic              clr_busy_reg;
    logic [AW-1:0]     clr_addr_reg;

    logic [MW-1:0]     rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [MW-1:0]     wr_data;

    // Stage 1: memory read outstanding.
    logic              st1_valid_reg;
    logic [AW-1:0]     st1_addr_reg;
    logic [XW-1:0]     st1_grad_reg;
    logic [XW-1:0]     st1_param_reg;
    logic signed [XW-1:0] m_old;
    logic [VW-1:0]     v_old;
    logic [VW-1:0]     v_old_c;
    logic signed [16:0] b1_s;
    logic [16:0]       w1;
    logic signed [17:0] w1_s;

    // Stage 2: decay products.
    logic              st2_valid_reg;
    logic [AW-1:0]     st2_addr_reg;
    logic [XW-1:0]     st2_grad_reg;
    logic [XW-1:0]     st2_param_reg;
    logic signed [48:0] st2_pm1_reg, st2_pm1_next;
    logic signed [49:0] st2_pm2_reg, st2_pm2_next;
    logic [63:0]       st2_pv1_reg, st2_pv1_next;

    // Stage 3: new momentum.
    logic              st3_valid_reg;
    logic [AW-1:0]     st3_addr_reg;
    logic [XW-1:0]     st3_grad_reg;
    logic [XW-1:0]     st3_param_reg;
    logic [63:0]       st3_pv1_reg;
    logic [XW-1:0]     st3_m_reg, st3_m_next;
    logic signed [50:0] msum;
    logic [34:0]       msh;

    // Stage 4: square of the selected sample.
    logic              st4_valid_reg;
    logic [AW-1:0]     st4_addr_reg;
    logic [XW-1:0]     st4_param_reg;
    logic [63:0]       st4_pv1_reg;
    logic [XW-1:0]     st4_m_reg;
    logic [63:0]       st4_sqp_reg, st4_sqp_next;
    logic [XW-1:0]     sq_src;
    logic [XW-1:0]     sq_mag;

    // Stage 5: new-sample velocity product; writes the memory.
    logic              st5_valid_reg;
    logic [AW-1:0]     st5_addr_reg;
    logic [XW-1:0]     st5_param_reg;
    logic [63:0]       st5_pv1_reg;
    logic [XW-1:0]     st5_m_reg;
    logic [63:0]       st5_pv2_reg, st5_pv2_next;
    logic [63:0]       sq_round;
    logic [16:0]       w2;

    // Stage 6: new velocity.
    logic              st6_valid_reg;
    logic [XW-1:0]     st6_param_reg;
    logic [XW-1:0]     st6_m_reg;
    logic [VW-1:0]     st6_v_reg, st6_v_next;
    logic [63:0]       vsum;
    logic [VW-1:0]     vraw;

    // Root pipeline.
    logic                        sq_valid;
    logic [adam_pkg::ROOT_W-1:0] sq_root;
    logic [SPW-1:0]              sq_payload;
    logic [XW-1:0]               sq_m;
    logic [XW-1:0]               sq_param;

    // Divider setup stage.
    logic                       dv_valid_reg;
    logic [adam_pkg::NUM_W-1:0] dv_num_reg, dv_num_next;
    logic [adam_pkg::DEN_W-1:0] dv_den_reg, dv_den_next;
    logic [XW-1:0]              dv_param_reg;
    logic                       dv_neg_reg;
    logic                       dv_mzero_reg, dv_mzero_next;
    logic                       dv_dzero_reg, dv_dzero_next;
    logic [XW-1:0]              m_mag;

    // Divider pipeline.
    logic                       div_valid;
    logic [adam_pkg::NUM_W-1:0] div_quot;
    logic [DPW-1:0]             div_payload;
    logic [XW-1:0]              div_param;
    logic                       div_neg;
    logic                       div_mzero;
    logic                       div_dzero;
    logic                       q_sat;
    logic [56:0]                q_lim;

    // Step products.
    logic              mul_valid_reg;
    logic [XW-1:0]     mul_param_reg;
    logic              mul_neg_reg;
    logic [56:0]       mul_ph_reg, mul_ph_next;
    logic [47:0]       mul_pl_reg, mul_pl_next;

    // Step sum.
    logic                        stp_valid_reg;
    logic [XW-1:0]               stp_param_reg;
    logic                        stp_neg_reg;
    logic [adam_pkg::STEP_W-1:0] stp_step_reg, stp_step_next;

    // Result.
    logic              res_valid_reg;
    logic [XW-1:0]     res_data_reg, res_data_next;
    logic signed [58:0] p_ext;
    logic signed [58:0] s_ext;
    logic signed [58:0] r_full;

    // Output register and skid register.
    logic              emit;
    logic              out_valid_reg, out_valid_next;
    logic [XW-1:0]     out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [XW-1:0]     skid_data_reg, skid_data_next;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= adam_pkg::CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                adam_pkg::REG_BETA_FIRST:  cfg_reg.beta_first  <= cfg_wdata[15:0];
                adam_pkg::REG_BETA_SECOND: cfg_reg.beta_second <= cfg_wdata[15:0];
                adam_pkg::REG_EPSILON:     cfg_reg.epsilon     <= cfg_wdata[15:0];
                adam_pkg::REG_LEARN_RATE:  cfg_reg.learn_rate  <= cfg_wdata;
                adam_pkg::REG_MAXIMIZE:    cfg_reg.maximize_mode <= cfg_wdata[0];
                adam_pkg::REG_MOMENTUM_SQ: cfg_reg.momentum_squared_mode <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input fields.
    assign in_idx   = s_tdata[IW-1:0];
    assign in_grad  = s_tdata[IW+XW-1:IW];
    assign in_param = s_tdata[IW+2*XW-1:IW+XW];

    // Index reduced into the memory range by conditional subtraction.
    always_comb begin
        idx_red = in_idx;
        for (int k = IW - 1; k >= 0; k--) begin
            if (32'(idx_red) >= 32'(ELEMENTS << k)) begin
                idx_red = idx_red - IW'(ELEMENTS << k);
            end
        end
        idx_ext = (IW + AW)'(idx_red);
    end
    assign in_addr = idx_ext[AW-1:0];

    // Gradient sign for maximize mode; the most negative value saturates.
    always_comb begin
        if (!cfg_reg.maximize_mode) begin
            grad_eff = in_grad;
        end else if (in_grad == adam_pkg::DATA_MIN) begin
            grad_eff = adam_pkg::DATA_MAX;
        end else begin
            grad_eff = (~in_grad) + 32'd1;
        end
    end

    // Interlock against elements whose moments are not yet written back.
    assign conflict = (st1_valid_reg && st1_addr_reg == in_addr)
                   || (st2_valid_reg && st2_addr_reg == in_addr)
                   || (st3_valid_reg && st3_addr_reg == in_addr)
                   || (st4_valid_reg && st4_addr_reg == in_addr)
                   || (st5_valid_reg && st5_addr_reg == in_addr);

    assign en       = ~skid_valid_reg;
    assign s_tready = en & ~clr_busy_reg & ~conflict;
    assign accept   = s_tvalid & s_tready;

    // Clearing pass over the memory after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Memory write port: clearing pass or stage 5 write-back.
    assign wr_en   = clr_busy_reg | (en & st5_valid_reg);
    assign wr_addr = clr_busy_reg ? clr_addr_reg : st5_addr_reg;
    assign wr_data = clr_busy_reg ? '0 : {st5_m_reg, st6_v_next};

    adam_state_ram #(
        .DEPTH (ELEMENTS),
        .AW    (AW),
        .DW    (MW)
    ) u_state_ram (
        .aclk    (aclk),
        .rd_en   (en),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Stage 1 math: decay products of the stored moments and the weighted gradient.
    always_comb begin
        m_old   = $signed(rd_data[MW-1:VW]);
        v_old   = rd_data[VW-1:0];
        v_old_c = (v_old > adam_pkg::VEL_CAP) ? adam_pkg::VEL_CAP : v_old;
        b1_s    = $signed({1'b0, cfg_reg.beta_first});
        w1      = 17'h10000 - {1'b0, cfg_reg.beta_first};
        w1_s    = $signed({1'b0, w1});
        st2_pm1_next = b1_s * m_old;
        st2_pm2_next = w1_s * $signed(st1_grad_reg);
        st2_pv1_next = cfg_reg.beta_second * v_old_c;
    end

    // Stage 2 math: rounded momentum, saturated to 32 bits.
    always_comb begin
        msum = st2_pm1_reg + st2_pm2_reg + 51'sd32768;
        msh  = msum[50:16];
        if ((&msh[34:31]) || !(|msh[34:31])) begin
            st3_m_next = msh[31:0];
        end else if (msh[34]) begin
            st3_m_next = adam_pkg::DATA_MIN;
        end else begin
            st3_m_next = adam_pkg::DATA_MAX;
        end
    end

    // Stage 3 math: square of gradient or new momentum.
    always_comb begin
        sq_src       = cfg_reg.momentum_squared_mode ? st3_m_reg : st3_grad_reg;
        sq_mag       = sq_src[XW-1] ? ((~sq_src) + 32'd1) : sq_src;
        st4_sqp_next = sq_mag * sq_mag;
    end

    // Stage 4 math: rounded square times the new-sample weight.
    always_comb begin
        sq_round     = st4_sqp_reg + 64'd32768;
        w2           = 17'h10000 - {1'b0, cfg_reg.beta_second};
        st5_pv2_next = w2 * sq_round[63:16];
    end

    // Stage 5 math: rounded, capped velocity.
    always_comb begin
        vsum       = st5_pv1_reg + st5_pv2_reg + 64'd32768;
        vraw       = vsum[63:16];
        st6_v_next = (vraw > adam_pkg::VEL_CAP) ? adam_pkg::VEL_CAP : vraw;
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            st6_valid_reg <= 1'b0;
            dv_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            stp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else if (en) begin
            st1_valid_reg <= accept;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
            st5_valid_reg <= st4_valid_reg;
            st6_valid_reg <= st5_valid_reg;
            dv_valid_reg  <= sq_valid;
            mul_valid_reg <= div_valid;
            stp_valid_reg <= mul_valid_reg;
            res_valid_reg <= stp_valid_reg;
        end
    end

    // Stage data.
    always_ff @(posedge aclk) begin
        if (en) begin
            st1_addr_reg  <= in_addr;
            st1_grad_reg  <= grad_eff;
            st1_param_reg <= in_param;

            st2_addr_reg  <= st1_addr_reg;
            st2_grad_reg  <= st1_grad_reg;
            st2_param_reg <= st1_param_reg;
            st2_pm1_reg   <= st2_pm1_next;
            st2_pm2_reg   <= st2_pm2_next;
            st2_pv1_reg   <= st2_pv1_next;

            st3_addr_reg  <= st2_addr_reg;
            st3_grad_reg  <= st2_grad_reg;
            st3_param_reg <= st2_param_reg;
            st3_pv1_reg   <= st2_pv1_reg;
            st3_m_reg     <= st3_m_next;

            st4_addr_reg  <= st3_addr_reg;
            st4_param_reg <= st3_param_reg;
            st4_pv1_reg   <= st3_pv1_reg;
            st4_m_reg     <= st3_m_reg;
            st4_sqp_reg   <= st4_sqp_next;

            st5_addr_reg  <= st4_addr_reg;
            st5_param_reg <= st4_param_reg;
            st5_pv1_reg   <= st4_pv1_reg;
            st5_m_reg     <= st4_m_reg;
            st5_pv2_reg   <= st5_pv2_next;

            st6_param_reg <= st5_param_reg;
            st6_m_reg     <= st5_m_reg;
            st6_v_reg     <= st6_v_next;

            dv_num_reg    <= dv_num_next;
            dv_den_reg    <= dv_den_next;
            dv_param_reg  <= sq_param;
            dv_neg_reg    <= sq_m[XW-1];
            dv_mzero_reg  <= dv_mzero_next;
            dv_dzero_reg  <= dv_dzero_next;

            mul_param_reg <= div_param;
            mul_neg_reg   <= div_neg;
            mul_ph_reg    <= mul_ph_next;
            mul_pl_reg    <= mul_pl_next;

            stp_param_reg <= mul_param_reg;
            stp_neg_reg   <= mul_neg_reg;
            stp_step_reg  <= stp_step_next;

            res_data_reg  <= res_data_next;
        end
    end

    // Root of the velocity, in units of 2^-24.
    adam_sqrt #(
        .PW (SPW)
    ) u_sqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (st6_valid_reg),
        .in_radicand ({st6_v_reg, 16'd0}),
        .in_payload  ({st6_m_reg, st6_param_reg}),
        .out_valid   (sq_valid),
        .out_root    (sq_root),
        .out_payload (sq_payload)
    );

    // Denominator and momentum magnitude for the divider.
    always_comb begin
        sq_m          = sq_payload[SPW-1:XW];
        sq_param      = sq_payload[XW-1:0];
        m_mag         = sq_m[XW-1] ? ((~sq_m) + 32'd1) : sq_m;
        dv_den_next   = {sq_root, 8'd0} + {24'd0, cfg_reg.epsilon};
        dv_num_next   = {m_mag, 32'd0};
        dv_mzero_next = (sq_m == '0);
        dv_dzero_next = (dv_den_next == '0);
    end

    adam_div #(
        .PW (DPW)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (dv_valid_reg),
        .in_num      (dv_num_reg),
        .in_den      (dv_den_reg),
        .in_payload  ({dv_param_reg, dv_neg_reg, dv_mzero_reg, dv_dzero_reg}),
        .out_valid   (div_valid),
        .out_quot    (div_quot),
        .out_payload (div_payload)
    );

    // Quotient limited to 2^56: beyond it any nonzero rate saturates the result.
    always_comb begin
        div_param = div_payload[DPW-1:3];
        div_neg   = div_payload[2];
        div_mzero = div_payload[1];
        div_dzero = div_payload[0];
        q_sat     = div_dzero | (|div_quot[63:56]);
        if (div_mzero) begin
            q_lim = '0;
        end else if (q_sat) begin
            q_lim = {1'b1, 56'd0};
        end else begin
            q_lim = {1'b0, div_quot[55:0]};
        end
        mul_ph_next = cfg_reg.learn_rate * q_lim[56:24];
        mul_pl_next = cfg_reg.learn_rate * q_lim[23:0];
    end

    // Step is the sum of the partial products.
    assign stp_step_next = mul_ph_reg + {33'd0, mul_pl_reg[47:24]};

    // Parameter update with 32-bit saturation.
    always_comb begin
        p_ext  = $signed({{27{stp_param_reg[XW-1]}}, stp_param_reg});
        s_ext  = $signed({2'b00, stp_step_reg});
        r_full = stp_neg_reg ? (p_ext + s_ext) : (p_ext - s_ext);
        if ((&r_full[58:31]) || !(|r_full[58:31])) begin
            res_data_next = r_full[31:0];
        end else if (r_full[58]) begin
            res_data_next = adam_pkg::DATA_MIN;
        end else begin
            res_data_next = adam_pkg::DATA_MAX;
        end
    end

    // Output register with a skid register behind it.
    assign emit = res_valid_reg & en;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (emit) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = 1'b1;
                out_data_next  = res_data_reg;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = res_data_reg;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The skid register only holds a result behind a full output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // The skid register fills only when the output was stalled.
    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid register filled without an output stall");

    // No element enters while the memory is being cleared.
    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !clr_busy_reg)
        else $error("transfer accepted during the clearing pass");

    // The clearing pass ends only after the last entry.
    a_clear_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_busy_reg) |-> ($past(clr_addr_reg) == LAST_ADDR))
        else $error("clearing pass ended early");

endmodule

// File: design/adam_state_ram.sv
// Simple dual-port state memory with a registered read port.
`timescale 1ns / 1ps

module adam_state_ram #(
    parameter int DEPTH = adam_pkg::ELEMENTS_DEFAULT,
    parameter int AW    = 10,
    parameter int DW    = adam_pkg::DATA_W + adam_pkg::VEL_W
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/adam_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side payload.
`timescale 1ns / 1ps

module adam_sqrt #(
    parameter int PW = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [adam_pkg::RAD_W-1:0]  in_radicand,
    input  logic [PW-1:0]               in_payload,
    output logic                        out_valid,
    output logic [adam_pkg::ROOT_W-1:0] out_root,
    output logic [PW-1:0]               out_payload
);

    localparam int STAGES = adam_pkg::ROOT_W;
    localparam int RW     = adam_pkg::RAD_W;

    logic [STAGES-1:0] valid_reg;
    logic [RW-1:0]     rem_reg     [STAGES];
    logic [RW-1:0]     res_reg     [STAGES];
    logic [PW-1:0]     payload_reg [STAGES];
    logic [RW-1:0]     rem_in      [STAGES];
    logic [RW-1:0]     res_in      [STAGES];
    logic [RW-1:0]     trial       [STAGES];
    logic [RW-1:0]     bit_val     [STAGES];
    logic [RW-1:0]     rem_next    [STAGES];
    logic [RW-1:0]     res_next    [STAGES];

    // Each stage tests one bit pair of the radicand, from the top down.
    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                rem_in[k] = in_radicand;
                res_in[k] = '0;
            end else begin
                rem_in[k] = rem_reg[k-1];
                res_in[k] = res_reg[k-1];
            end
            bit_val[k] = RW'(1) << (RW - 2 - 2 * k);
            trial[k]   = res_in[k] + bit_val[k];
            if (rem_in[k] >= trial[k]) begin
                rem_next[k] = rem_in[k] - trial[k];
                res_next[k] = (res_in[k] >> 1) + bit_val[k];
            end else begin
                rem_next[k] = rem_in[k];
                res_next[k] = res_in[k] >> 1;
            end
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // Stage data.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
                if (k == 0) begin
                    payload_reg[k] <= in_payload;
                end else begin
                    payload_reg[k] <= payload_reg[k-1];
                end
            end
        end
    end

    assign out_valid   = valid_reg[STAGES-1];
    assign out_root    = res_reg[STAGES-1][adam_pkg::ROOT_W-1:0];
    assign out_payload = payload_reg[STAGES-1];

endmodule

// File: design/adam_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
`timescale 1ns / 1ps

module adam_div #(
    parameter int PW = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [adam_pkg::NUM_W-1:0] in_num,
    input  logic [adam_pkg::DEN_W-1:0] in_den,
    input  logic [PW-1:0]              in_payload,
    output logic                       out_valid,
    output logic [adam_pkg::NUM_W-1:0] out_quot,
    output logic [PW-1:0]              out_payload
);

    localparam int NW     = adam_pkg::NUM_W;
    localparam int DW     = adam_pkg::DEN_W;
    localparam int STAGES = NW;

    logic [STAGES-1:0] valid_reg;
    logic [DW-1:0]     rem_reg     [STAGES];
    logic [NW-1:0]     nq_reg      [STAGES];
    logic [DW-1:0]     den_reg     [STAGES];
    logic [PW-1:0]     payload_reg [STAGES];
    logic [DW-1:0]     rem_in      [STAGES];
    logic [NW-1:0]     nq_in       [STAGES];
    logic [DW-1:0]     den_in      [STAGES];
    logic [DW:0]       partial     [STAGES];
    logic [DW:0]       diff        [STAGES];
    logic [DW-1:0]     rem_next    [STAGES];
    logic [NW-1:0]     nq_next     [STAGES];

    // The numerator shifts out at the top while quotient bits shift in below.
    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                rem_in[k] = '0;
                nq_in[k]  = in_num;
                den_in[k] = in_den;
            end else begin
                rem_in[k] = rem_reg[k-1];
                nq_in[k]  = nq_reg[k-1];
                den_in[k] = den_reg[k-1];
            end
            partial[k] = {rem_in[k], nq_in[k][NW-1]};
            diff[k]    = partial[k] - {1'b0, den_in[k]};
            if (partial[k] >= {1'b0, den_in[k]}) begin
                rem_next[k] = diff[k][DW-1:0];
                nq_next[k]  = {nq_in[k][NW-2:0], 1'b1};
            end else begin
                rem_next[k] = partial[k][DW-1:0];
                nq_next[k]  = {nq_in[k][NW-2:0], 1'b0};
            end
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // Stage data.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                den_reg[k] <= den_in[k];
                if (k == 0) begin
                    payload_reg[k] <= in_payload;
                end else begin
                    payload_reg[k] <= payload_reg[k-1];
                end
            end
        end
    end

    assign out_valid   = valid_reg[STAGES-1];
    assign out_quot    = nq_reg[STAGES-1];
    assign out_payload = payload_reg[STAGES-1];

endmodule

// File: sim/tb_adam_optimizer_update.sv
// Self-checking testbench for the Adam parameter update block, with a built-in predictor.
`timescale 1ns / 1ps

module tb_adam_optimizer_update;

    localparam int NUM_ELEMS = 1024;
    localparam int DRAIN_CYCLES = 120;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [adam_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [adam_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_we;
    logic [adam_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [adam_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // Predictor copy of the configuration and of the moment stores.
    longint            beta1_q;
    longint            beta2_q;
    longint            eps_q;
    longint            lr_q;
    bit                maximize_q;
    bit                msq_mode_q;
    logic [31:0]       moment_mem [NUM_ELEMS];
    logic [47:0]       velocity_mem [NUM_ELEMS];

    logic [31:0]       expected_params [$];
    int                mismatches;
    int                elements_sent;
    int                results_seen;
    int                settings_used;
    bit                idle_on;
    int                hold_off_cycles;

    adam_optimizer_update #(.ELEMENTS(NUM_ELEMS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Integer square root, rounded down.
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_q824(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Computes the updated parameter and advances the moment stores.
    function automatic logic [31:0] predict_param(logic [9:0] idx, logic [31:0] grad,
                                                  logic [31:0] pval);
        longint          g;
        longint          p;
        longint          m_old;
        longint          m;
        longint          s;
        longint          mag;
        longint          sq;
        longint          v_old;
        longint          v;
        longint unsigned root;
        longint unsigned den;
        longint unsigned mm;
        longint unsigned quo;
        longint unsigned step;
        longint          res;
        g = longint'(signed'(grad));
        p = longint'(signed'(pval));
        m_old = longint'(signed'(moment_mem[idx]));
        v_old = longint'({16'd0, velocity_mem[idx]});
        if (maximize_q) begin
            g = -g;
            if (g > 64'sd2147483647) g = 64'sd2147483647;
        end
        m = (beta1_q * m_old + (65536 - beta1_q) * g + 32768) >>> 16;
        m = clamp_q824(m);
        s = msq_mode_q ? m : g;
        mag = (s < 0) ? -s : s;
        sq = (mag * mag + 32768) >> 16;
        if (v_old > (64'sd1 << 46)) v_old = 64'sd1 << 46;
        v = (beta2_q * v_old + (65536 - beta2_q) * sq + 32768) >> 16;
        if (v > (64'sd1 << 46)) v = 64'sd1 << 46;
        moment_mem[idx] = m[31:0];
        velocity_mem[idx] = v[47:0];
        root = int_sqrt(longint'(unsigned'(v)) << 16);
        den = (root << 8) + longint'(unsigned'(eps_q));
        mm = (m < 0) ? longint'(unsigned'(-m)) : longint'(unsigned'(m));
        if (mm == 0) quo = 0;
        else if (den == 0) quo = 64'd1 << 63;
        else quo = (mm << 32) / den;
        if (quo > (64'd1 << 63)) quo = 64'd1 << 63;
        step = longint'(unsigned'(lr_q)) * (quo >> 24)
             + ((longint'(unsigned'(lr_q)) * (quo & 64'hFF_FFFF)) >> 24);
        if (step > (64'd1 << 40)) step = 64'd1 << 40;
        if (m < 0) res = p + longint'(step);
        else res = p - longint'(step);
        res = clamp_q824(res);
        return res[31:0];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        mismatches++;
        $display("MISMATCH %s: expected %h got %h at %0t", what, exp_v, got_v, $realtime);
    endtask

    // Sends one element; the expectation is formed at the transfer.
    task automatic send_element(logic [9:0] idx, logic [31:0] grad, logic [31:0] pval);
        while (idle_on && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, pval, grad, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_params.push_back(predict_param(idx, grad, pval));
        elements_sent++;
    endtask

    // Stops offering and waits until every result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_params.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Drives one register write; the caller drops the write enable after the last one.
    task automatic write_reg(adam_pkg::cfg_reg_t idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            adam_pkg::REG_BETA_FIRST:  beta1_q = val[15:0];
            adam_pkg::REG_BETA_SECOND: beta2_q = val[15:0];
            adam_pkg::REG_EPSILON:     eps_q = val[15:0];
            adam_pkg::REG_LEARN_RATE:  lr_q = val;
            adam_pkg::REG_MAXIMIZE:    maximize_q = val[0];
            adam_pkg::REG_MOMENTUM_SQ: msq_mode_q = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [15:0] b1, logic [15:0] b2, logic [15:0] eps,
                                 logic [23:0] lr, bit maxm, bit msq);
        drain_results();
        write_reg(adam_pkg::REG_BETA_FIRST, {8'd0, b1});
        write_reg(adam_pkg::REG_BETA_SECOND, {8'd0, b2});
        write_reg(adam_pkg::REG_EPSILON, {8'd0, eps});
        write_reg(adam_pkg::REG_LEARN_RATE, lr);
        write_reg(adam_pkg::REG_MAXIMIZE, {23'd0, maxm});
        write_reg(adam_pkg::REG_MOMENTUM_SQ, {23'd0, msq});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Values for gradients and parameters, mixing full-range words with small and boundary values.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 400)) - 200);
            3: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int count, int idx_span);
        repeat (count) begin
            send_element(10'($urandom_range(0, idx_span - 1)), pick_value(), pick_value());
        end
    endtask

    // Boundary fields, both modes, zero denominator and the largest quotients.
    task automatic test_directed();
        send_element(10'd0, 32'h0100_0000, 32'h0000_0000);
        send_element(10'd0, 32'h0100_0000, 32'h0100_0000);
        send_element(10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_element(10'd1023, 32'h8000_0000, 32'h8000_0000);
        send_element(10'd5, 32'h0000_0000, 32'h1234_5678);
        send_element(10'd6, 32'hFFFF_FFFF, 32'h8000_0000);
        apply_setting(16'd0, 16'd0, 16'd0, 24'hFF_FFFF, 1'b1, 1'b0);
        // Negating the most negative gradient saturates.
        send_element(10'd10, 32'h8000_0000, 32'h0000_0000);
        send_element(10'd11, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // A tiny gradient leaves zero velocity, so the denominator is zero.
        send_element(10'd12, 32'h0000_0001, 32'h0000_0000);
        send_element(10'd13, 32'hFFFF_FFFF, 32'h0000_0000);
        send_element(10'd14, 32'h0000_0000, 32'h7FFF_FFFF);
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0, 1'b0, 1'b1);
        send_element(10'd20, 32'h7FFF_FFFF, 32'h0000_0000);
        send_element(10'd20, 32'h8000_0000, 32'h8000_0000);
        send_element(10'd21, 32'h5555_5555, 32'hAAAA_AAAA);
        apply_setting(16'd1, 16'd1, 16'd1, 24'hFF_FFFF, 1'b0, 1'b1);
        send_element(10'd30, 32'h0000_0100, 32'h0000_0000);
        send_element(10'd30, 32'h8000_0000, 32'h7FFF_FFFF);
        send_element(10'd31, 32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    // Random elements under a range of settings, on a small index set and the full one.
    task automatic test_random();
        apply_setting(16'd58982, 16'd65470, 16'd43, 24'd16777, 1'b0, 1'b0);
        send_random(100, 8);
        repeat (4) begin
            apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                          1'($urandom), 1'($urandom));
            send_random(60, 16);
            send_random(40, NUM_ELEMS);
        end
    endtask

    // A stretch with no idling on either side.
    task automatic test_full_rate();
        apply_setting(16'd60000, 16'd65000, 16'd100, 24'd200000, 1'b1, 1'b1);
        idle_on = 1'b0;
        send_random(150, 64);
        drain_results();
        idle_on = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills.
    task automatic test_backpressure();
        apply_setting(16'd50000, 16'd60000, 16'd7, 24'd1000000, 1'b0, 1'b0);
        hold_off_cycles = 400;
        send_random(200, 32);
    endtask

    // Counts down the receiver hold-off.
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
    end

    // Checks each result transfer and drives the receiver ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_params.size() == 0) begin
                report_mismatch("unexpected result", 32'h0, m_tdata);
            end else begin
                if (m_tdata !== expected_params[0]) begin
                    report_mismatch("new_param", expected_params[0], m_tdata);
                end
                void'(expected_params.pop_front());
            end
        end
        m_tready <= (hold_off_cycles == 0) && (!idle_on || $urandom_range(0, 99) >= 37);
    end

    // Overall time limit.
    initial begin
        #4000000;
        $display("Timeout waiting for results");
        $display("Verification failed");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        elements_sent = 0;
        results_seen = 0;
        settings_used = 0;
        idle_on = 1'b1;
        hold_off_cycles = 0;
        beta1_q = adam_pkg::CFG_RESET.beta_first;
        beta2_q = adam_pkg::CFG_RESET.beta_second;
        eps_q = adam_pkg::CFG_RESET.epsilon;
        lr_q = adam_pkg::CFG_RESET.learn_rate;
        maximize_q = adam_pkg::CFG_RESET.maximize_mode;
        msq_mode_q = adam_pkg::CFG_RESET.momentum_squared_mode;
        for (int i = 0; i < NUM_ELEMS; i++) begin
            moment_mem[i] = '0;
            velocity_mem[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random();
        test_full_rate();
        test_backpressure();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_params.size() != 0) begin
            report_mismatch("missing result", expected_params[0], 32'h0);
        end
        $display("Sent %0d elements and checked %0d results under %0d register settings,",
                 elements_sent, results_seen, settings_used);
        $display("including both modes, zero denominator, saturation and a long output stall.");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
